// ----- design/view_rotation_accumulator_top_defines.svh -----
`ifndef VIEW_ROTATION_ACCUMULATOR_TOP_DEFINES_SVH
`define VIEW_ROTATION_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk outside of reset.
`define VRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk outside of reset.
`define VRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/vra_pkg.sv -----
`timescale 1ns / 1ps

package vra_pkg;

  typedef logic signed [15:0] q_t;
  typedef logic [2:0][2:0][15:0] mat_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_STEP = 3'd4;

  localparam logic [1:0] DIR_LEFT = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP = 2'd2;
  localparam logic [1:0] DIR_DOWN = 2'd3;

  localparam logic [1:0] PH_ROT = 2'd0;
  localparam logic [1:0] PH_CONJ = 2'd1;
  localparam logic [1:0] PH_USER = 2'd2;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc_first;
    logic acc;
    logic wr;
    logic commit;
    logic [1:0] phase;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
  } vra_cmd_t;

  function automatic q_t sat_neg(q_t v);
    q_t r;
    if (v == 16'sh8000) begin
      r = 16'sh7fff;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // One entry of the screen-space step rotation.
  function automatic q_t rv_entry(logic [1:0] dir, q_t c, q_t s_cfg, q_t one,
                                  logic [1:0] r, logic [1:0] col);
    q_t s;
    q_t ns;
    q_t e;
    s = (dir == DIR_RIGHT || dir == DIR_DOWN) ? s_cfg : sat_neg(s_cfg);
    ns = sat_neg(s);
    e = '0;
    if (dir == DIR_LEFT || dir == DIR_RIGHT) begin
      case ({r, col})
        4'b0000: e = c;
        4'b0001: e = ns;
        4'b0100: e = s;
        4'b0101: e = c;
        4'b1010: e = one;
        default: e = '0;
      endcase
    end else begin
      case ({r, col})
        4'b0000: e = one;
        4'b0101: e = c;
        4'b0110: e = ns;
        4'b1001: e = s;
        4'b1010: e = c;
        default: e = '0;
      endcase
    end
    return e;
  endfunction

endpackage

// ----- design/vra_ctrl.sv -----
`timescale 1ns / 1ps

`include "view_rotation_accumulator_top_defines.svh"

module vra_ctrl import vra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output vra_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] i_r, i_nxt;
  logic [1:0] j_r, j_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    i_nxt = i_r;
    j_nxt = j_r;
    step_nxt = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    cmd.phase = phase_r;
    cmd.i = i_r;
    cmd.j = j_r;
    cmd.k = (step_r <= 3'd2) ? step_r[1:0] : 2'd0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          state_nxt = S_RUN;
          phase_nxt = PH_ROT;
          i_nxt = 2'd0;
          j_nxt = 2'd0;
          step_nxt = 3'd0;
        end
      end
      S_RUN: begin
        cmd.mul = (step_r <= 3'd2);
        cmd.acc_first = (step_r == 3'd1);
        cmd.acc = (step_r == 3'd2) || (step_r == 3'd3);
        cmd.wr = (step_r == 3'd4);
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd4) begin
          step_nxt = 3'd0;
          if (j_r == 2'd2) begin
            j_nxt = 2'd0;
            if (i_r == 2'd2) begin
              i_nxt = 2'd0;
              if (phase_r == PH_USER) begin
                state_nxt = S_DONE;
              end else begin
                phase_nxt = phase_r + 2'd1;
              end
            end else begin
              i_nxt = i_r + 2'd1;
            end
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_ROT;
      i_r <= 2'd0;
      j_r <= 2'd0;
      step_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      step_r <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `VRA_ASSERT_NEXT(a_start_runs, accept, state_r == S_RUN)
  `VRA_ASSERT_NOW(a_busy_blocks_input, state_r != S_IDLE, !in_ready)
  `VRA_ASSERT_NOW(a_commit_slot_free, cmd.commit, slot_free)
  `VRA_ASSERT_NOW(a_step_range, state_r == S_RUN, step_r <= 3'd4 && phase_r <= PH_USER)

endmodule

// ----- design/vra_dp.sv -----
`timescale 1ns / 1ps

module vra_dp import vra_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vra_cmd_t              cmd,
  input  logic [1:0]            in_direction,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output mat_t                  u_mat
);

  localparam int ACC_W = 35;
  localparam q_t ONE = (FRAC_BITS >= 15) ? 16'sh7fff : q_t'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam mat_t U_IDENT = {16'h4000, 48'h0, 16'h4000, 48'h0, 16'h4000};

  logic [CFG_DATA_W-1:0]    base_r [0:2];
  q_t                       cos_r;
  q_t                       sin_r;
  mat_t                     u_r;
  mat_t                     t_r;
  mat_t                     w_r;
  logic [1:0]               dir_r;
  logic signed [31:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic [1:0]               bcol;
  q_t                       bsel;
  q_t                       op_a;
  q_t                       op_b;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shf;
  q_t                       res;

  assign bcol = (cmd.phase == PH_ROT) ? cmd.j : cmd.i;
  assign bsel = q_t'(base_r[cmd.k][{bcol, 4'b0000} +: 16]);

  always_comb begin
    case (cmd.phase)
      PH_ROT: begin
        op_a = rv_entry(dir_r, cos_r, sin_r, ONE, cmd.i, cmd.k);
        op_b = bsel;
      end
      PH_CONJ: begin
        op_a = bsel;
        op_b = q_t'(t_r[cmd.k][cmd.j]);
      end
      default: begin
        op_a = q_t'(w_r[cmd.i][cmd.k]);
        op_b = q_t'(u_r[cmd.k][cmd.j]);
      end
    endcase
  end

  assign rnd = acc_r + RND;
  assign shf = rnd >>> FRAC_BITS;

  always_comb begin
    if (shf > 35'sd32767) begin
      res = 16'sh7fff;
    end else if (shf < -35'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = shf[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir_r <= in_direction;
    end
    if (cmd.mul) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.acc_first) begin
      acc_r <= ACC_W'(prod_r);
    end else if (cmd.acc) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.wr) begin
      if (cmd.phase == PH_CONJ) begin
        w_r[cmd.i][cmd.j] <= res;
      end else begin
        t_r[cmd.i][cmd.j] <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0] <= 48'd16384;
      base_r[1] <= 48'd16384 << 16;
      base_r[2] <= 48'd16384 << 32;
      cos_r <= 16'sd16364;
      sin_r <= 16'sd819;
      u_r <= U_IDENT;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_ROW0: base_r[0] <= cfg_wdata;
          CFG_BASE_ROW1: base_r[1] <= cfg_wdata;
          CFG_BASE_ROW2: base_r[2] <= cfg_wdata;
          CFG_COS_STEP:  cos_r <= cfg_wdata[15:0];
          CFG_SIN_STEP:  sin_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        u_r <= t_r;
      end
    end
  end

  assign u_mat = u_r;

endmodule

// ----- design/view_rotation_accumulator_top.sv -----
`timescale 1ns / 1ps

// An accepted transaction runs three phases that compute 27 matrix entries in turn
// on one shared 16x16 multiplier; the result is then committed and out_valid raised once
// the output slot is free. A new transaction is accepted only after that commit.
// A new transaction is accepted while the previous result waits on out_ready.
// Reset (rst_n low, synchronous) loads the base matrix, step cosine and sine
// defaults and sets the user matrix to identity.

module view_rotation_accumulator_top import vra_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_direction,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_u_r0c0,
  output logic signed [15:0]    out_u_r0c1,
  output logic signed [15:0]    out_u_r0c2,
  output logic signed [15:0]    out_u_r1c0,
  output logic signed [15:0]    out_u_r1c1,
  output logic signed [15:0]    out_u_r1c2,
  output logic signed [15:0]    out_u_r2c0,
  output logic signed [15:0]    out_u_r2c1,
  output logic signed [15:0]    out_u_r2c2,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  vra_cmd_t cmd;
  mat_t     u_mat;

  vra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  vra_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_direction (in_direction),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .u_mat        (u_mat)
  );

  assign out_u_r0c0 = u_mat[0][0];
  assign out_u_r0c1 = u_mat[0][1];
  assign out_u_r0c2 = u_mat[0][2];
  assign out_u_r1c0 = u_mat[1][0];
  assign out_u_r1c1 = u_mat[1][1];
  assign out_u_r1c2 = u_mat[1][2];
  assign out_u_r2c0 = u_mat[2][0];
  assign out_u_r2c1 = u_mat[2][1];
  assign out_u_r2c2 = u_mat[2][2];

endmodule

// ----- verif/view_rotation_accumulator_top_tb.sv -----
`timescale 1ns / 1ps

module view_rotation_accumulator_top_tb;
  import vra_pkg::*;

  localparam int FRAC = 14;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] ROW_IDX [3] = '{CFG_BASE_ROW0, CFG_BASE_ROW1, CFG_BASE_ROW2};

  localparam int STEP_COS [8] = '{16364, 16384, 0, 11585, 14189, 15137, 16305, 8192};
  localparam int STEP_SIN [8] = '{819, 0, 16384, 11585, 8192, 6270, 1606, 14189};
  localparam int PERMS [6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2},
                                  '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};

  typedef logic [8:0][15:0] mat9_t;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [1:0]            dir;
    bit                    typed;
    mat9_t                 want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] in_direction = DIR_LEFT;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE_ROW0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_ready;
  logic out_valid;
  logic signed [15:0] out_u_r0c0, out_u_r0c1, out_u_r0c2;
  logic signed [15:0] out_u_r1c0, out_u_r1c1, out_u_r1c2;
  logic signed [15:0] out_u_r2c0, out_u_r2c1, out_u_r2c2;

  logic [CFG_DATA_W-1:0] base_row_m [3];
  q_t cos_m;
  q_t sin_m;
  mat9_t user_m;
  mat9_t expected_q [$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  string field_name [9] = '{"u_r0c0", "u_r0c1", "u_r0c2", "u_r1c0", "u_r1c1",
                            "u_r1c2", "u_r2c0", "u_r2c1", "u_r2c2"};

  view_rotation_accumulator_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_direction (in_direction),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_u_r0c0   (out_u_r0c0),
    .out_u_r0c1   (out_u_r0c1),
    .out_u_r0c2   (out_u_r0c2),
    .out_u_r1c0   (out_u_r1c0),
    .out_u_r1c1   (out_u_r1c1),
    .out_u_r1c2   (out_u_r1c2),
    .out_u_r2c0   (out_u_r2c0),
    .out_u_r2c1   (out_u_r2c1),
    .out_u_r2c2   (out_u_r2c2),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic q_t sat16(longint v);
    return (v > 32767) ? 16'sh7fff : (v < -32768) ? 16'sh8000 : q_t'(v);
  endfunction

  function automatic mat9_t round_mul(mat9_t a, mat9_t b);
    mat9_t r;
    longint acc;
    int i, j, k;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        acc = 0;
        for (k = 0; k < 3; k++) begin
          acc += longint'($signed(a[i*3+k])) * longint'($signed(b[k*3+j]));
        end
        acc += longint'(1) << (FRAC - 1);
        r[i*3+j] = sat16(acc >>> FRAC);
      end
    end
    return r;
  endfunction

  function automatic mat9_t next_user(logic [1:0] dir);
    mat9_t rv, b, bt, w;
    q_t one, s;
    int i, j;
    one = sat16(longint'(1) << FRAC);
    s = (dir == DIR_RIGHT || dir == DIR_DOWN) ? sin_m : sat16(-longint'(sin_m));
    rv = '0;
    if (dir == DIR_LEFT || dir == DIR_RIGHT) begin
      rv[0] = cos_m;
      rv[1] = sat16(-longint'(s));
      rv[3] = s;
      rv[4] = cos_m;
      rv[8] = one;
    end else begin
      rv[0] = one;
      rv[4] = cos_m;
      rv[5] = sat16(-longint'(s));
      rv[7] = s;
      rv[8] = cos_m;
    end
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        b[i*3+j] = base_row_m[i][16*j +: 16];
        bt[j*3+i] = base_row_m[i][16*j +: 16];
      end
    end
    w = round_mul(rv, b);
    w = round_mul(bt, w);
    return round_mul(w, user_m);
  endfunction

  function automatic step_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_row_t r;
    r = '{1'b1, idx, data, DIR_LEFT, 1'b0, '0};
    return r;
  endfunction

  function automatic step_row_t item_row(logic [1:0] dir, bit typed, mat9_t want);
    step_row_t r;
    r = '{1'b0, CFG_BASE_ROW0, '0, dir, typed, want};
    return r;
  endfunction

  // The register is written only once every outstanding result has been taken.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_BASE_ROW0: base_row_m[0] = data;
      CFG_BASE_ROW1: base_row_m[1] = data;
      CFG_BASE_ROW2: base_row_m[2] = data;
      CFG_COS_STEP: cos_m = data[15:0];
      CFG_SIN_STEP: sin_m = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] dir, bit typed, mat9_t want);
    mat9_t predicted;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_direction <= dir;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_user(dir);
    user_m = predicted;
    expected_q.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    mat9_t got, want;
    int i;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rst_n && out_valid && out_ready) begin
      got = {out_u_r2c2, out_u_r2c1, out_u_r2c0, out_u_r1c2, out_u_r1c1,
             out_u_r1c0, out_u_r0c2, out_u_r0c1, out_u_r0c0};
      if (expected_q.size() == 0) begin
        $error("Result transaction arrived with no expectation waiting.");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        for (i = 0; i < 9; i++) begin
          if (got[i] !== want[i]) begin
            $error("%s: expected %0d, actual %0d", field_name[i],
                   $signed(want[i]), $signed(got[i]));
            fail_count++;
          end
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    step_row_t rows [$];
    mat9_t ident, rot_z, rot_x;
    logic [CFG_DATA_W-1:0] row;
    logic [63:0] noise;
    q_t c, s;
    int phase, r, pick;

    base_row_m[0] = 48'h0000_0000_4000;
    base_row_m[1] = 48'h0000_4000_0000;
    base_row_m[2] = 48'h4000_0000_0000;
    cos_m = 16'sd16364;
    sin_m = 16'sd819;
    ident = '0;
    ident[0] = 16'h4000;
    ident[4] = 16'h4000;
    ident[8] = 16'h4000;
    user_m = ident;
    rot_z = '0;
    rot_z[1] = 16'hC000;
    rot_z[3] = 16'h4000;
    rot_z[8] = 16'h4000;
    rot_x = '0;
    rot_x[0] = 16'h4000;
    rot_x[5] = 16'h4000;
    rot_x[7] = 16'hC000;

    rows.push_back(reg_row(CFG_COS_STEP, 48'd16384));
    rows.push_back(reg_row(CFG_SIN_STEP, 48'd0));
    rows.push_back(item_row(DIR_RIGHT, 1'b1, ident));
    rows.push_back(item_row(DIR_UP, 1'b1, ident));
    rows.push_back(reg_row(CFG_COS_STEP, 48'd0));
    rows.push_back(reg_row(CFG_SIN_STEP, 48'd16384));
    rows.push_back(item_row(DIR_RIGHT, 1'b1, rot_z));
    rows.push_back(item_row(DIR_LEFT, 1'b1, ident));
    rows.push_back(item_row(DIR_UP, 1'b1, rot_x));
    rows.push_back(item_row(DIR_DOWN, 1'b1, ident));
    rows.push_back(reg_row(CFG_UNUSED_LO, 48'hFFFF_FFFF_FFFF));
    rows.push_back(reg_row(CFG_UNUSED_HI, 48'h0000_0000_4000));
    rows.push_back(item_row(DIR_RIGHT, 1'b1, rot_z));
    rows.push_back(item_row(DIR_LEFT, 1'b1, ident));
    rows.push_back(reg_row(CFG_COS_STEP, 48'hFFFF_FFFF_4000));
    rows.push_back(reg_row(CFG_SIN_STEP, 48'h8000_1234_0000));
    rows.push_back(item_row(DIR_DOWN, 1'b1, ident));
    rows.push_back(reg_row(CFG_COS_STEP, 48'd0));
    rows.push_back(reg_row(CFG_SIN_STEP, 48'h0000_0000_8000));
    rows.push_back(item_row(DIR_LEFT, 1'b0, '0));
    rows.push_back(item_row(DIR_RIGHT, 1'b0, '0));
    rows.push_back(reg_row(CFG_COS_STEP, 48'd16364));
    rows.push_back(reg_row(CFG_SIN_STEP, 48'd819));
    rows.push_back(reg_row(CFG_BASE_ROW0, 48'h0000_4000_0000));
    rows.push_back(reg_row(CFG_BASE_ROW1, 48'hC000_0000_0000));
    rows.push_back(reg_row(CFG_BASE_ROW2, 48'h0000_0000_4000));
    rows.push_back(item_row(DIR_LEFT, 1'b0, '0));
    rows.push_back(item_row(DIR_RIGHT, 1'b0, '0));
    rows.push_back(item_row(DIR_UP, 1'b0, '0));
    rows.push_back(item_row(DIR_DOWN, 1'b0, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[n]) begin
      if (rows[n].is_write) begin
        write_reg(rows[n].idx, rows[n].data);
      end else begin
        send_item(rows[n].dir, rows[n].typed, rows[n].want);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct <= 13;
        recv_idle_pct <= 73;
      end else if (phase < 6) begin
        send_idle_pct <= 73;
        recv_idle_pct <= 13;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (phase < 7) begin
        pick = $urandom_range(5);
        for (r = 0; r < 3; r++) begin
          row = '0;
          row[16*PERMS[pick][r] +: 16] = $urandom_range(1) ? 16'h4000 : 16'hC000;
          write_reg(ROW_IDX[r], row);
        end
        pick = $urandom_range(7);
        c = q_t'(STEP_COS[pick]);
        s = q_t'(STEP_SIN[pick]);
        if ($urandom_range(1)) begin
          c = -c;
        end
        if ($urandom_range(1)) begin
          s = -s;
        end
        noise = {$urandom, $urandom};
        write_reg(CFG_COS_STEP, {noise[31:0], c});
        write_reg(CFG_SIN_STEP, {noise[63:32], s});
      end else if (phase == 7) begin
        for (r = 0; r < 3; r++) begin
          noise = {$urandom, $urandom};
          write_reg(ROW_IDX[r], noise[CFG_DATA_W-1:0]);
        end
        noise = {$urandom, $urandom};
        write_reg(CFG_COS_STEP, noise[CFG_DATA_W-1:0]);
        noise = {$urandom, $urandom};
        write_reg(CFG_SIN_STEP, noise[CFG_DATA_W-1:0]);
      end else begin
        write_reg(CFG_BASE_ROW0, 48'h7FFF_8000_7FFF);
        write_reg(CFG_BASE_ROW1, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_BASE_ROW2, 48'h8000_7FFF_0000);
        write_reg(CFG_COS_STEP, 48'h0000_0000_8000);
        write_reg(CFG_SIN_STEP, 48'h0000_0000_7FFF);
      end
      noise = {$urandom, $urandom};
      write_reg($urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, noise[CFG_DATA_W-1:0]);
      // The receiver stalls long enough for the block to back up its input.
      if (phase == 6) begin
        hold_req <= ~hold_req;
      end
      repeat (ITEMS_PER_PHASE) send_item(2'($urandom_range(3)), 1'b0, '0);
    end

    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
